@@ rtl/pcl_pkg.sv @@
// pcl_pkg: types, codes and sizes shared by the positional character list
// depends on nothing; imported by every module of the block
package pcl_pkg;

   // capacity of the cell chain, derived index and count widths, position and byte widths
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;
   localparam int BYTE_W   = 8;

   // request operation
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_DUMP   = 2'd3
   } kind_type;

   // response status
   typedef enum logic [1:0] {
      STATUS_DATA   = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_END    = 2'd3
   } status_type;

   // per-cell update broadcast along the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // sequencer states
   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_DUMP = 1'b1
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [POS_W-1:0]    position;
      logic [BYTE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BYTE_W-1:0]   data_byte;
      logic                last;
   } rsp_type;

   typedef struct packed {
      cell_op_type         op;
      logic [POS_W-1:0]    pos0;
      logic [BYTE_W-1:0]   value;
   } cell_cmd_type;

endpackage

@@ rtl/pcl_cell.sv @@
// pcl_cell: one storage cell of the list chain, holds a single byte
// depends on pcl_pkg; instanced CAPACITY times by positional_char_list_unit
module pcl_cell
   import pcl_pkg::*;
(
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [IDX_W-1:0]    my_index,
   input  logic [BYTE_W-1:0]   left_q,
   input  logic [BYTE_W-1:0]   right_q,
   output logic [BYTE_W-1:0]   q
);

   logic [BYTE_W-1:0] elem_ff;
   logic [BYTE_W-1:0] elem_in;
   logic [POS_W-1:0]  idx;

   assign idx = POS_W'(my_index);

   // insert: slot takes the new byte, cells behind it shift from the left
   // delete: the slot and cells behind it shift from the right
   always_comb begin
      elem_in = elem_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (idx == cmd.pos0) begin
               elem_in = cmd.value;
            end else if (idx > cmd.pos0) begin
               elem_in = left_q;
            end
         end
         CELL_DELETE: begin
            if (idx >= cmd.pos0) begin
               elem_in = right_q;
            end
         end
         default: begin
            elem_in = elem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign q = elem_ff;

endmodule

@@ rtl/positional_char_list_unit.sv @@
// positional_char_list_unit: ordered byte list held in a shifting cell chain
// depends on pcl_pkg and pcl_cell
//
//   channel | ports                          | payload  | direction
//   request | req_valid, req_stall, req_data | req_type | in
//   result  | rsp_valid, rsp_stall, rsp_data | rsp_type | out
//
// insert and delete update the cells and read loads the result register; a new request is
// taken in the next cycle as long as the result register is free or being drained
// dump returns each element and then an end marker, one result per cycle out of the chain read
// port while the result side is not stalled; requests are stalled until the end marker is registered
// synchronous reset empties the list; cell contents are not cleared
// a stalled result holds the result register and stalls the request side
module positional_char_list_unit
   import pcl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   dump_idx_ff, dump_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               req_take;
   logic [POS_W-1:0]   pos0;
   logic [CNT_W:0]     pos_ext;
   logic               pos_nonzero;
   logic               ins_pos_ok;
   logic               in_range;
   logic               is_full;
   logic [IDX_W-1:0]   rd_idx;
   logic [BYTE_W-1:0]  rd_byte;
   cell_cmd_type       cmd;
   logic [BYTE_W-1:0]  cell_q [CAPACITY];

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != STATE_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   // position checks
   assign pos0        = req_data.position - POS_W'(1);
   assign pos_ext     = (CNT_W + 1)'(req_data.position);
   assign pos_nonzero = (req_data.position != '0);
   assign ins_pos_ok  = pos_nonzero && (pos_ext <= ({1'b0, count_ff} + (CNT_W + 1)'(1)));
   assign in_range    = pos_nonzero && (pos_ext <= {1'b0, count_ff});
   assign is_full     = (count_ff == CNT_W'(CAPACITY));

   // chain read port, shared by read and dump; a dump starts at the head
   assign rd_idx  = (state_ff == STATE_DUMP)     ? dump_idx_ff[IDX_W-1:0] :
                    (req_data.kind == KIND_DUMP) ? IDX_W'(0) :
                    pos0[IDX_W-1:0];
   assign rd_byte = cell_q[rd_idx];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_take && req_data.kind == KIND_DUMP && count_ff != '0) begin
               state_in = STATE_DUMP;
            end
         end
         STATE_DUMP: begin
            if (out_free && dump_idx_ff == count_ff) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // outputs: result register, dump counter, chain command, count
   always_comb begin
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rsp_data_in           = rsp_data_ff;
      dump_idx_in           = dump_idx_ff;
      count_in              = count_ff;
      cmd.op                = CELL_HOLD;
      cmd.pos0              = pos0;
      cmd.value             = req_data.value;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_take) begin
               unique case (req_data.kind)
                  KIND_INSERT: begin
                     if (!ins_pos_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{STATUS_BADPOS, '0, 1'b1};
                     end else if (is_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{STATUS_FULL, '0, 1'b1};
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_DELETE: begin
                     if (!in_range) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{STATUS_BADPOS, '0, 1'b1};
                     end else begin
                        cmd.op   = CELL_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  KIND_READ: begin
                     rsp_valid_in = 1'b1;
                     if (in_range) begin
                        rsp_data_in = '{STATUS_DATA, rd_byte, 1'b1};
                     end else begin
                        rsp_data_in = '{STATUS_BADPOS, '0, 1'b1};
                     end
                  end
                  KIND_DUMP: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_data_in = '{STATUS_END, '0, 1'b1};
                     end else begin
                        rsp_data_in = '{STATUS_DATA, rd_byte, 1'b0};
                        dump_idx_in = CNT_W'(1);
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         STATE_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (dump_idx_ff == count_ff) begin
                  rsp_data_in = '{STATUS_END, '0, 1'b1};
               end else begin
                  rsp_data_in = '{STATUS_DATA, rd_byte, 1'b0};
                  dump_idx_in = dump_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cell chain; ends see their own value or the inserted byte
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [BYTE_W-1:0] left_q;
      logic [BYTE_W-1:0] right_q;
      if (g == 0) begin : g_head
         assign left_q = req_data.value;
      end else begin : g_body
         assign left_q = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_q = cell_q[g];
      end else begin : g_inner
         assign right_q = cell_q[g+1];
      end
      pcl_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .my_index (IDX_W'(g)),
         .left_q   (left_q),
         .right_q  (right_q),
         .q        (cell_q[g])
      );
   end

endmodule

@@ rtl/pcl_checker.sv @@
// pcl_checker: port-level checks on the positional character list
// depends on pcl_pkg; bound to positional_char_list_unit below
module pcl_checker
   import pcl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stall,
   input  req_type  req_data,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  rsp_type  rsp_data
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // mid-dump data means the request side is held off
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_DATA && !rsp_data.last |-> req_stall)
      else $error("request taken during dump");

   // every non-data status closes its transaction with a zero byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DATA |-> rsp_data.last && rsp_data.data_byte == '0)
      else $error("non-data result without last or with data");

endmodule

bind positional_char_list_unit pcl_checker u_pcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
